/* rtl/mqap_pkg.sv */
// Shared types and constants for the MQTT ack and publish packet checker.
`default_nettype none

package mqap_pkg;

    // Field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned ROLE_W     = 2;
    localparam int unsigned CAP_W      = 9;
    localparam int unsigned INDEX_W    = 9;
    localparam int unsigned TOPIC_W    = 16;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 32;

    // Output tdata bit positions
    localparam int unsigned OUT_STATUS_BIT = 8;
    localparam int unsigned OUT_TLEN_LSB   = 9;
    localparam int unsigned OUT_PLEN_LSB   = 17;
    localparam int unsigned OUT_USED_W     = 25;

    // Header constants
    localparam logic [BYTE_W-1:0] CONNACK_HDR  = 8'h20;
    localparam logic [BYTE_W-1:0] TYPE_MASK    = 8'hF0;
    localparam logic [BYTE_W-1:0] SUBACK_HDR   = 8'h90;
    localparam logic [BYTE_W-1:0] SUBACK_FAIL  = 8'h80;
    localparam logic [3:0]        PUBLISH_TYPE = 4'd3;

    localparam logic [CAP_W-1:0]   CAP_RESET = 9'd256;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 9'd511;

    // Expected packet kind, sampled on the first byte
    typedef enum logic [MODE_W-1:0] {
        KIND_CONNACK = 2'd0,
        KIND_SUBACK  = 2'd1,
        KIND_PUBLISH = 2'd2,
        KIND_UNUSED  = 2'd3    // accepts nothing
    } kind_t;

    // Tag carried with each byte
    typedef enum logic [ROLE_W-1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_TOPIC   = 2'd1,
        ROLE_PAYLOAD = 2'd2
    } role_t;

endpackage

`default_nettype wire

/* rtl/mqtt_ack_publish_parser.sv */
// Top level of the MQTT ack and publish packet checker.
//
// Checks one received packet byte per cycle unless m_tready stalls the output: an item
// on the slave side is one byte (tlast marks the final byte of the buffer, tuser the
// expected kind: CONNACK, SUBACK or PUBLISH QoS0, sampled on the first byte). Each byte
// comes back out two register stages later, the input register and the result register
// around a single stage of compare logic, tagged through tuser as header, topic or
// payload; the item carrying tlast also carries the verdict and, for an accepted PUBLISH,
// the topic and payload lengths. Tagged bytes of a packet that ends rejected must be
// discarded downstream. cfg_data sets the topic buffer capacity (reset 256); the user
// must write it only while the block is idle, which the block itself does not enforce.
`default_nettype none

module mqtt_ack_publish_parser
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write: topic capacity
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mqap_pkg::CAP_W-1:0]        cfg_data,
    // Input bytes
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mqap_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  wire logic                              s_tlast,   // last
    input  wire logic [mqap_pkg::MODE_W-1:0]       s_tuser,   // [1:0] mode
    // Output bytes and verdict
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mqap_pkg::OUT_DATA_W-1:0]        m_tdata,   // [7:0] out_byte, [8] status,
                                                              // [16:9] topic_length,
                                                              // [24:17] payload_length,
                                                              // [31:25] zero
    output logic                                   m_tlast,   // done_res
    output logic [mqap_pkg::ROLE_W-1:0]            m_tuser    // [1:0] role
);

    // Configuration register
    logic [mqap_pkg::CAP_W-1:0] cap_reg;

    // Input register
    logic                            in_valid_reg;
    logic [mqap_pkg::BYTE_W-1:0]     in_byte_reg;
    logic                            in_last_reg;
    logic [mqap_pkg::MODE_W-1:0]     in_mode_reg;

    // Packet state
    logic [mqap_pkg::INDEX_W-1:0]    idx_reg,  idx_next;
    mqap_pkg::kind_t                 kind_reg, kind_next;
    logic [mqap_pkg::BYTE_W-1:0]     rc_reg,   rc_next;
    logic [mqap_pkg::TOPIC_W-1:0]    ts_reg,   ts_next;
    logic                            rej_reg,  rej_next;

    // Result register
    logic                            out_valid_reg;
    logic [mqap_pkg::BYTE_W-1:0]     out_byte_reg;
    logic                            out_last_reg;
    logic                            out_status_reg, status_next;
    logic [mqap_pkg::BYTE_W-1:0]     out_tlen_reg,   tlen_next;
    logic [mqap_pkg::BYTE_W-1:0]     out_plen_reg,   plen_next;
    mqap_pkg::role_t                 out_role_reg,   role_next;

    logic advance;
    logic in_take;

    // Work signals
    mqap_pkg::kind_t                 kind_cur;
    logic [mqap_pkg::BYTE_W-1:0]     rc_cur;
    logic [mqap_pkg::TOPIC_W-1:0]    ts_cur;
    logic                            bad;
    logic [mqap_pkg::BYTE_W-1:0]     b;
    logic [mqap_pkg::INDEX_W-1:0]    i;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || !out_valid_reg || m_tready;
    assign in_take   = s_tvalid && s_tready;

    // Topic capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= mqap_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata[mqap_pkg::BYTE_W-1:0];
            in_last_reg <= s_tlast;
            in_mode_reg <= s_tuser;
        end
    end

    // Per-byte checks
    always_comb
    begin
        b         = in_byte_reg;
        i         = idx_reg;
        kind_cur  = (i == '0) ? mqap_pkg::kind_t'(in_mode_reg) : kind_reg;
        rc_cur    = rc_reg;
        ts_cur    = ts_reg;
        bad       = rej_reg;
        role_next = mqap_pkg::ROLE_HEADER;
        tlen_next = '0;
        plen_next = '0;

        unique case (kind_cur)
            mqap_pkg::KIND_CONNACK:
            begin
                if (i == 9'd0 && b != mqap_pkg::CONNACK_HDR) bad = 1'b1;
                if (i == 9'd3 && b != 8'd0) bad = 1'b1;
                if (in_last_reg && i < 9'd3) bad = 1'b1;
            end
            mqap_pkg::KIND_SUBACK:
            begin
                if (i == 9'd0 && (b & mqap_pkg::TYPE_MASK) != mqap_pkg::SUBACK_HDR)
                    bad = 1'b1;
                if (in_last_reg && (i < 9'd4 || b == mqap_pkg::SUBACK_FAIL)) bad = 1'b1;
            end
            mqap_pkg::KIND_PUBLISH:
            begin
                if (i == 9'd0 && b[7:4] != mqap_pkg::PUBLISH_TYPE) bad = 1'b1;
                if (i == 9'd1)
                begin
                    rc_cur = b;
                    if (b < 8'd2) bad = 1'b1;
                end
                if (i == 9'd2) ts_cur = {b, 8'd0};
                if (i == 9'd3)
                begin
                    ts_cur = {ts_reg[15:8], b};
                    if ({1'b0, ts_cur} + 17'd2 > {9'd0, rc_reg}) bad = 1'b1;
                    if ({1'b0, ts_cur} + 17'd1 > {8'd0, cap_reg}) bad = 1'b1;
                end
                if (in_last_reg &&
                    (i < 9'd3 || {1'b0, i} + 10'd1 < {2'd0, rc_cur} + 10'd2))
                    bad = 1'b1;
                // Topic and payload tagging
                if (!bad && i >= 9'd4)
                begin
                    if ({8'd0, i} < {1'b0, ts_cur} + 17'd4)
                        role_next = mqap_pkg::ROLE_TOPIC;
                    else if ({1'b0, i} < {2'd0, rc_cur} + 10'd2)
                        role_next = mqap_pkg::ROLE_PAYLOAD;
                end
                if (in_last_reg && !bad)
                begin
                    tlen_next = ts_cur[7:0];
                    plen_next = rc_cur - 8'd2 - ts_cur[7:0];
                end
            end
            default:
            begin
                // Unused mode: never accepted
                if (in_last_reg) bad = 1'b1;
            end
        endcase

        status_next = in_last_reg && bad;
    end

    // Next packet state
    always_comb
    begin
        if (in_last_reg)
        begin
            idx_next  = '0;
            kind_next = mqap_pkg::KIND_CONNACK;
            rc_next   = '0;
            ts_next   = '0;
            rej_next  = 1'b0;
        end
        else
        begin
            idx_next  = (idx_reg < mqap_pkg::INDEX_MAX) ? idx_reg + 9'd1 : mqap_pkg::INDEX_MAX;
            kind_next = kind_cur;
            rc_next   = rc_cur;
            ts_next   = ts_cur;
            rej_next  = bad;
        end
    end

    // Packet state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            kind_reg <= mqap_pkg::KIND_CONNACK;
            rc_reg   <= '0;
            ts_reg   <= '0;
            rej_reg  <= 1'b0;
        end
        else if (advance)
        begin
            idx_reg  <= idx_next;
            kind_reg <= kind_next;
            rc_reg   <= rc_next;
            ts_reg   <= ts_next;
            rej_reg  <= rej_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg   <= in_byte_reg;
            out_last_reg   <= in_last_reg;
            out_status_reg <= status_next;
            out_tlen_reg   <= tlen_next;
            out_plen_reg   <= plen_next;
            out_role_reg   <= role_next;
        end
    end

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_role_reg;
    assign m_tdata  = {{(mqap_pkg::OUT_DATA_W - mqap_pkg::OUT_USED_W){1'b0}},
                       out_plen_reg, out_tlen_reg, out_status_reg, out_byte_reg};

endmodule

`default_nettype wire

/* rtl/mqap_checker.sv */
// Port-level checker for the MQTT ack and publish packet checker, with its bind.
`default_nettype none

module mqap_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [mqap_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  wire logic                              m_tlast,
    input  wire logic [mqap_pkg::ROLE_W-1:0]       m_tuser
);

    // A stalled result item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Verdict fields are zero except on the final byte
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[mqap_pkg::OUT_USED_W-1:mqap_pkg::OUT_STATUS_BIT] == '0)
        else $error("verdict fields set before the final byte");

    // A rejected packet reports no lengths
    a_reject_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[mqap_pkg::OUT_STATUS_BIT]
            |-> m_tdata[mqap_pkg::OUT_USED_W-1:mqap_pkg::OUT_TLEN_LSB] == '0)
        else $error("lengths reported on a rejected packet");

    // The rejecting final byte is never tagged
    a_reject_role: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tdata[mqap_pkg::OUT_STATUS_BIT]
            |-> m_tuser == mqap_pkg::ROLE_HEADER)
        else $error("rejecting final byte carries a tag");

    // Padding bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[mqap_pkg::OUT_DATA_W-1:mqap_pkg::OUT_USED_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind mqtt_ack_publish_parser mqap_checker u_mqap_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
